// ===== rtl/pfa_pkg.sv =====
// Package with the sizes, status codes and helpers of the page frame allocator.
package pfa_pkg;

  localparam int FRAME_COUNT     = 64;
  localparam int RESERVED_FRAMES = 16;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
  localparam int MAX_PAGES       = 48;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int COUNT_W = $clog2(FRAME_COUNT + 1);
  localparam int OWNER_W = 8;
  localparam int BYTES_W = 19;
  localparam int PAGES_W = BYTES_W + 1 - PAGE_SHIFT;

  localparam logic [1:0] ST_CONTIG  = 2'd0;
  localparam logic [1:0] ST_SCATTER = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_FREED   = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [FRAME_COUNT-1:0] frame_vec_t;

  function automatic frame_vec_t reserved_mask();
    frame_vec_t m;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      m[i] = (i < RESERVED_FRAMES);
    end
    return m;
  endfunction

endpackage

// ===== rtl/page_frame_allocator.sv =====
// First-fit page frame allocator: frame table, request sequencer and result register.
//
// A transaction is taken when start is high and busy is low. An allocate walks the
// 64-entry frame table once (one frame a cycle) to count free frames and find the
// lowest contiguous run, then decides (answering no-space if the request cannot be
// met), and then delivers one result per page at one per cycle; a scattered allocate
// walks the table a second time and delivers a result on each free frame it takes. A
// free walks the owner memory frame by frame (read, then compare) before its result.
// A zero-byte allocate answers in the cycle after it is taken.
// Results appear on the out_ ports for exactly one cycle with out_valid high and
// must be taken then, since the receiver cannot stall the block; busy stays high
// until the cycle that carries the last result of the transaction, in which it is
// already low so that the next transaction can be taken at the end of that cycle.
module page_frame_allocator
  import pfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_op,
  input  logic [OWNER_W-1:0]     in_owner_id,
  input  logic [BYTES_W-1:0]     in_request_bytes,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic                   out_has_mapping,
  output logic [5:0]             out_page_index,
  output logic [5:0]             out_frame_number,
  output logic [6:0]             out_frames_freed,
  output logic                   out_last
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_CONTIG   = 3'd3;
  localparam logic [2:0] S_SCATTER  = 3'd4;
  localparam logic [2:0] S_FREE_RD  = 3'd5;
  localparam logic [2:0] S_FREE_CHK = 3'd6;

  localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(FRAME_COUNT - 1);

  logic [2:0]          state_r, state_nxt;
  frame_vec_t          frame_busy_r, frame_busy_nxt;
  logic [OWNER_W-1:0]  owner_mem [FRAME_COUNT];
  logic [OWNER_W-1:0]  owner_rd_r;
  logic                mem_we;
  logic [FRAME_W-1:0]  mem_waddr;

  logic [OWNER_W-1:0]  owner_r, owner_nxt;
  logic [PAGES_W-1:0]  pages_r, pages_nxt;
  logic [FRAME_W-1:0]  idx_r, idx_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  run_len_r, run_len_nxt;
  logic [FRAME_W-1:0]  run_start_r, run_start_nxt;
  logic                found_r, found_nxt;
  logic [FRAME_W-1:0]  found_start_r, found_start_nxt;
  logic [FRAME_W-1:0]  k_r, k_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_map_r, out_map_nxt;
  logic [5:0]          out_page_r, out_page_nxt;
  logic [5:0]          out_frame_r, out_frame_nxt;
  logic [6:0]          out_freed_r, out_freed_nxt;
  logic                out_last_r, out_last_nxt;

  logic [BYTES_W:0]    bytes_round;
  logic [PAGES_W-1:0]  in_pages;
  logic [COUNT_W-1:0]  run_len_inc;
  logic [FRAME_W-1:0]  contig_frame;
  logic                page_is_last_contig;
  logic                page_is_last_scatter;

  assign bytes_round = {1'b0, in_request_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1);
  assign in_pages    = bytes_round[BYTES_W:PAGE_SHIFT];
  assign run_len_inc = run_len_r + COUNT_W'(1);
  assign contig_frame = found_start_r + k_r;
  assign page_is_last_contig  = ({{(PAGES_W-FRAME_W){1'b0}}, k_r} + PAGES_W'(1)) == pages_r;
  assign page_is_last_scatter = page_is_last_contig;

  always_comb begin
    state_nxt       = state_r;
    frame_busy_nxt  = frame_busy_r;
    owner_nxt       = owner_r;
    pages_nxt       = pages_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    run_len_nxt     = run_len_r;
    run_start_nxt   = run_start_r;
    found_nxt       = found_r;
    found_start_nxt = found_start_r;
    k_nxt           = k_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_map_nxt     = out_map_r;
    out_page_nxt    = out_page_r;
    out_frame_nxt   = out_frame_r;
    out_freed_nxt   = out_freed_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          owner_nxt   = in_owner_id;
          pages_nxt   = in_pages;
          idx_nxt     = '0;
          cnt_nxt     = '0;
          run_len_nxt = '0;
          found_nxt   = 1'b0;
          k_nxt       = '0;
          if (in_op == OP_FREE) begin
            state_nxt = S_FREE_RD;
          end else if (in_pages == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CONTIG;
            out_map_nxt    = 1'b0;
            out_page_nxt   = '0;
            out_frame_nxt  = '0;
            out_freed_nxt  = '0;
            out_last_nxt   = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!frame_busy_r[idx_r]) begin
          cnt_nxt     = cnt_r + COUNT_W'(1);
          run_len_nxt = run_len_inc;
          if (run_len_r == '0) begin
            run_start_nxt = idx_r;
          end
          if (!found_r && ({{(PAGES_W-COUNT_W){1'b0}}, run_len_inc} == pages_r)) begin
            found_nxt       = 1'b1;
            found_start_nxt = (run_len_r == '0) ? idx_r : run_start_r;
          end
        end else begin
          run_len_nxt = '0;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + FRAME_W'(1);
        end
      end
      S_DECIDE: begin
        idx_nxt = '0;
        k_nxt   = '0;
        if ((owner_r == '0) || (pages_r > PAGES_W'(MAX_PAGES)) ||
            (pages_r > {{(PAGES_W-COUNT_W){1'b0}}, cnt_r})) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOSPACE;
          out_map_nxt    = 1'b0;
          out_page_nxt   = '0;
          out_frame_nxt  = '0;
          out_freed_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else if (found_r) begin
          state_nxt = S_CONTIG;
        end else begin
          state_nxt = S_SCATTER;
        end
      end
      S_CONTIG: begin
        frame_busy_nxt[contig_frame] = 1'b1;
        mem_we         = 1'b1;
        mem_waddr      = contig_frame;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_CONTIG;
        out_map_nxt    = 1'b1;
        out_page_nxt   = 6'(k_r);
        out_frame_nxt  = 6'(contig_frame);
        out_freed_nxt  = '0;
        out_last_nxt   = page_is_last_contig;
        k_nxt          = k_r + FRAME_W'(1);
        if (page_is_last_contig) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCATTER: begin
        idx_nxt = idx_r + FRAME_W'(1);
        if (!frame_busy_r[idx_r]) begin
          frame_busy_nxt[idx_r] = 1'b1;
          mem_we         = 1'b1;
          mem_waddr      = idx_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_SCATTER;
          out_map_nxt    = 1'b1;
          out_page_nxt   = 6'(k_r);
          out_frame_nxt  = 6'(idx_r);
          out_freed_nxt  = '0;
          out_last_nxt   = page_is_last_scatter;
          k_nxt          = k_r + FRAME_W'(1);
          if (page_is_last_scatter) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (frame_busy_r[idx_r] && (int'(idx_r) >= RESERVED_FRAMES) &&
            (owner_r != '0) && (owner_rd_r == owner_r)) begin
          frame_busy_nxt[idx_r] = 1'b0;
          cnt_nxt = cnt_r + COUNT_W'(1);
        end
        if (idx_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FREED;
          out_map_nxt    = 1'b0;
          out_page_nxt   = '0;
          out_frame_nxt  = '0;
          out_freed_nxt  = 7'(cnt_nxt);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_r + FRAME_W'(1);
          state_nxt = S_FREE_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[mem_waddr] <= owner_r;
    end
    owner_rd_r <= owner_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_busy_r <= reserved_mask();
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_busy_r <= frame_busy_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r       <= owner_nxt;
    pages_r       <= pages_nxt;
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    run_len_r     <= run_len_nxt;
    run_start_r   <= run_start_nxt;
    found_r       <= found_nxt;
    found_start_r <= found_start_nxt;
    k_r           <= k_nxt;
    out_status_r  <= out_status_nxt;
    out_map_r     <= out_map_nxt;
    out_page_r    <= out_page_nxt;
    out_frame_r   <= out_frame_nxt;
    out_freed_r   <= out_freed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_has_mapping  = out_map_r;
  assign out_page_index   = out_page_r;
  assign out_frame_number = out_frame_r;
  assign out_frames_freed = out_freed_r;
  assign out_last         = out_last_r;

  a_map_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_mapping |-> (out_status == ST_CONTIG) || (out_status == ST_SCATTER))
    else $error("mapping result with a non-allocate status");

  a_freed_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_FREED) || (out_status == ST_NOSPACE)) |-> out_last)
    else $error("single-result transaction without last");

  a_mapped_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_mapping |-> frame_busy_r[FRAME_W'(out_frame_number)])
    else $error("mapped frame is not marked busy");

  a_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_busy_r & reserved_mask()) == reserved_mask())
    else $error("reserved frame was released");

  a_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("block went idle before the last result");

endmodule
